### sv/szl_pkg.sv
`default_nettype none
package szl_pkg;

  localparam int STAGES   = 4;
  localparam int CHANNELS = 2;
  localparam int FIELDS   = 2;

  localparam int SMP_W  = 24;
  localparam int COEF_W = 24;
  localparam int K_W    = 16;
  localparam int GAIN_W = 24;
  localparam int REG_W  = 2;

  localparam int IDX_W = (STAGES > 0) ? $clog2(STAGES + 1) : 1;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Divider yields this many quotient bits, one per cycle.
  localparam int DIV_STEPS = 26;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [REG_W-1:0] REG_RES_K    = 2'd0;
  localparam logic [REG_W-1:0] REG_IN_GAIN  = 2'd1;
  localparam logic [REG_W-1:0] REG_OUT_GAIN = 2'd2;

  localparam logic [K_W-1:0]    RES_K_RST    = 16'd8192;
  localparam logic [GAIN_W-1:0] IN_GAIN_RST  = 24'd524288;
  localparam logic [GAIN_W-1:0] OUT_GAIN_RST = 24'd1048576;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV_START, OP_DIV_STEP, OP_G_SET,
    OP_PW_M, OP_PW_W, OP_X_M, OP_X_W, OP_CO_M, OP_CO_W, OP_SM_M, OP_SM_W,
    OP_KS_M, OP_KS_W, OP_KP_M, OP_KP_W, OP_U_ONE, OP_A2_M, OP_A2_W,
    OP_AN_M, OP_V_SET, OP_ST_M, OP_ST_W, OP_OUT_M, OP_OUT_W, OP_PUBLISH
  } dp_op_t;

  typedef enum logic [1:0] {
    DIV_G, DIV_FB, DIV_CLIP
  } div_sel_t;

  typedef struct packed {
    dp_op_t           op;
    div_sel_t         div_sel;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] pw_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic overload;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GDIV0, ST_GDIV, ST_GSET, ST_PW_M, ST_PW_W,
    ST_X_M, ST_X_W, ST_CO_M, ST_CO_W, ST_SM_M, ST_SM_W,
    ST_KS_M, ST_KS_W, ST_KP_M, ST_KP_W, ST_CMP, ST_FBDIV,
    ST_A2_M, ST_A2_W, ST_AN_M, ST_AN_W, ST_CLDIV, ST_V_SET,
    ST_ST_M, ST_ST_W, ST_OUT_M, ST_OUT_W, ST_DONE
  } ctl_state_t;

endpackage
`default_nettype wire

### sv/szl_in_if.sv
`default_nettype none
interface szl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [szl_pkg::SMP_W-1:0]    left_in;
  logic signed [szl_pkg::SMP_W-1:0]    right_in;
  logic        [szl_pkg::COEF_W-1:0]   cutoff_coef;

  modport source (output valid, left_in, right_in, cutoff_coef, input ready);
  modport sink (input valid, left_in, right_in, cutoff_coef, output ready);
endinterface
`default_nettype wire

### sv/szl_out_if.sv
`default_nettype none
interface szl_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [szl_pkg::SMP_W-1:0] left_out;
  logic signed [szl_pkg::SMP_W-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

### sv/szl_cfg_if.sv
`default_nettype none
interface szl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [szl_pkg::REG_W-1:0]        index;
  logic [szl_pkg::GAIN_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/szl_ctl.sv
`default_nettype none
module szl_ctl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire szl_pkg::dp_stat_t  stat,
  output szl_pkg::dp_cmd_t        cmd
);

  localparam int IDX_W  = szl_pkg::IDX_W;
  localparam int CH_W   = szl_pkg::CH_W;
  localparam int DCNT_W = szl_pkg::DCNT_W;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(szl_pkg::STAGES - 1);
  localparam logic [IDX_W-1:0]  IDX_TOP   = IDX_W'(szl_pkg::STAGES);
  localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(szl_pkg::CHANNELS - 1);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(szl_pkg::DIV_STEPS - 1);

  szl_pkg::ctl_state_t state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= szl_pkg::ST_IDLE;
      idx_r       <= '0;
      ch_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd.op        = szl_pkg::OP_NONE;
    cmd.div_sel   = szl_pkg::DIV_G;
    cmd.ch        = ch_r;
    cmd.idx       = idx_r;
    cmd.pw_addr   = idx_r;

    unique case (state_r)
      szl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = szl_pkg::OP_LOAD;
          state_nxt = szl_pkg::ST_GDIV0;
        end
      end
      szl_pkg::ST_GDIV0: begin
        cmd.op      = szl_pkg::OP_DIV_START;
        cmd.div_sel = szl_pkg::DIV_G;
        cnt_nxt     = '0;
        state_nxt   = szl_pkg::ST_GDIV;
      end
      szl_pkg::ST_GDIV: begin
        cmd.op  = szl_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DCNT_LAST) state_nxt = szl_pkg::ST_GSET;
      end
      szl_pkg::ST_GSET: begin
        cmd.op    = szl_pkg::OP_G_SET;
        idx_nxt   = IDX_W'(1);
        state_nxt = szl_pkg::ST_PW_M;
      end
      szl_pkg::ST_PW_M: begin
        cmd.op      = szl_pkg::OP_PW_M;
        cmd.pw_addr = idx_r - 1'b1;
        state_nxt   = szl_pkg::ST_PW_W;
      end
      szl_pkg::ST_PW_W: begin
        cmd.op = szl_pkg::OP_PW_W;
        if (idx_r == IDX_TOP) begin
          ch_nxt    = '0;
          state_nxt = szl_pkg::ST_X_M;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = szl_pkg::ST_PW_M;
        end
      end
      szl_pkg::ST_X_M: begin
        cmd.op    = szl_pkg::OP_X_M;
        state_nxt = szl_pkg::ST_X_W;
      end
      szl_pkg::ST_X_W: begin
        cmd.op    = szl_pkg::OP_X_W;
        idx_nxt   = '0;
        state_nxt = szl_pkg::ST_CO_M;
      end
      szl_pkg::ST_CO_M: begin
        cmd.op      = szl_pkg::OP_CO_M;
        cmd.pw_addr = IDX_LAST - idx_r;
        state_nxt   = szl_pkg::ST_CO_W;
      end
      szl_pkg::ST_CO_W: begin
        cmd.op    = szl_pkg::OP_CO_W;
        state_nxt = szl_pkg::ST_SM_M;
      end
      szl_pkg::ST_SM_M: begin
        cmd.op    = szl_pkg::OP_SM_M;
        state_nxt = szl_pkg::ST_SM_W;
      end
      szl_pkg::ST_SM_W: begin
        cmd.op = szl_pkg::OP_SM_W;
        if (idx_r == IDX_LAST) begin
          state_nxt = szl_pkg::ST_KS_M;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = szl_pkg::ST_CO_M;
        end
      end
      szl_pkg::ST_KS_M: begin
        cmd.op    = szl_pkg::OP_KS_M;
        state_nxt = szl_pkg::ST_KS_W;
      end
      szl_pkg::ST_KS_W: begin
        cmd.op    = szl_pkg::OP_KS_W;
        state_nxt = szl_pkg::ST_KP_M;
      end
      szl_pkg::ST_KP_M: begin
        cmd.op      = szl_pkg::OP_KP_M;
        cmd.pw_addr = IDX_TOP;
        state_nxt   = szl_pkg::ST_KP_W;
      end
      szl_pkg::ST_KP_W: begin
        cmd.op    = szl_pkg::OP_KP_W;
        state_nxt = szl_pkg::ST_CMP;
      end
      szl_pkg::ST_CMP: begin
        // Overdriven feedback: skip both divisions, clip to full scale.
        if (stat.overload) begin
          cmd.op    = szl_pkg::OP_U_ONE;
          idx_nxt   = '0;
          state_nxt = szl_pkg::ST_ST_M;
        end else begin
          cmd.op      = szl_pkg::OP_DIV_START;
          cmd.div_sel = szl_pkg::DIV_FB;
          cnt_nxt     = '0;
          state_nxt   = szl_pkg::ST_FBDIV;
        end
      end
      szl_pkg::ST_FBDIV: begin
        cmd.op  = szl_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DCNT_LAST) state_nxt = szl_pkg::ST_A2_M;
      end
      szl_pkg::ST_A2_M: begin
        cmd.op    = szl_pkg::OP_A2_M;
        state_nxt = szl_pkg::ST_A2_W;
      end
      szl_pkg::ST_A2_W: begin
        cmd.op    = szl_pkg::OP_A2_W;
        state_nxt = szl_pkg::ST_AN_M;
      end
      szl_pkg::ST_AN_M: begin
        cmd.op    = szl_pkg::OP_AN_M;
        state_nxt = szl_pkg::ST_AN_W;
      end
      szl_pkg::ST_AN_W: begin
        cmd.op      = szl_pkg::OP_DIV_START;
        cmd.div_sel = szl_pkg::DIV_CLIP;
        cnt_nxt     = '0;
        state_nxt   = szl_pkg::ST_CLDIV;
      end
      szl_pkg::ST_CLDIV: begin
        cmd.op  = szl_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DCNT_LAST) state_nxt = szl_pkg::ST_V_SET;
      end
      szl_pkg::ST_V_SET: begin
        cmd.op    = szl_pkg::OP_V_SET;
        idx_nxt   = '0;
        state_nxt = szl_pkg::ST_ST_M;
      end
      szl_pkg::ST_ST_M: begin
        cmd.op    = szl_pkg::OP_ST_M;
        state_nxt = szl_pkg::ST_ST_W;
      end
      szl_pkg::ST_ST_W: begin
        cmd.op = szl_pkg::OP_ST_W;
        if (idx_r == IDX_LAST) begin
          state_nxt = szl_pkg::ST_OUT_M;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = szl_pkg::ST_ST_M;
        end
      end
      szl_pkg::ST_OUT_M: begin
        cmd.op    = szl_pkg::OP_OUT_M;
        state_nxt = szl_pkg::ST_OUT_W;
      end
      szl_pkg::ST_OUT_W: begin
        cmd.op = szl_pkg::OP_OUT_W;
        if (ch_r == CH_LAST) begin
          state_nxt = szl_pkg::ST_DONE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = szl_pkg::ST_X_M;
        end
      end
      szl_pkg::ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.op        = szl_pkg::OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = szl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = szl_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/szl_datapath.sv
`default_nettype none
module szl_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire szl_pkg::dp_cmd_t                    cmd,
  output szl_pkg::dp_stat_t                        stat,
  input  wire logic signed [szl_pkg::SMP_W-1:0]    left_in,
  input  wire logic signed [szl_pkg::SMP_W-1:0]    right_in,
  input  wire logic        [szl_pkg::COEF_W-1:0]   cutoff_coef,
  input  wire logic        [szl_pkg::K_W-1:0]      res_k,
  input  wire logic        [szl_pkg::GAIN_W-1:0]   in_gain,
  input  wire logic        [szl_pkg::GAIN_W-1:0]   out_gain,
  output logic signed      [szl_pkg::SMP_W-1:0]    left_out,
  output logic signed      [szl_pkg::SMP_W-1:0]    right_out
);

  localparam int STAGES   = szl_pkg::STAGES;
  localparam int CHANNELS = szl_pkg::CHANNELS;
  localparam int SMP_W    = szl_pkg::SMP_W;
  localparam int NST      = CHANNELS * STAGES;
  localparam int SA_W     = (NST > 1) ? $clog2(NST) : 1;

  localparam int G_W   = 25;
  localparam int ST_W  = 32;
  localparam int S_W   = 36;
  localparam int X_W   = 30;
  localparam int NUM_W = 40;
  localparam int DEN_W = 28;
  localparam int A2_W  = 28;
  localparam int V_W   = 34;
  localparam int D_W   = 36;
  localparam int MA_W  = 36;
  localparam int MB_W  = 27;
  localparam int P_W   = 63;
  localparam int REM_W = 64;
  localparam int DVS_W = 32;
  localparam int DSR_W = DVS_W + szl_pkg::DIV_STEPS - 1;
  localparam int Q_W   = szl_pkg::DIV_STEPS;

  localparam logic [G_W-1:0]          ONE_G   = 25'd16777216;
  localparam logic [G_W-1:0]          G_BIAS  = 25'd1048576;
  localparam logic signed [V_W-1:0]   ONE_V   = 34'sd16777216;
  localparam logic [DVS_W-1:0]        C27     = 32'd452984832;
  localparam logic signed [S_W:0]     ST_MAX  = 37'sd2147483647;
  localparam logic signed [S_W:0]     ST_MIN  = -37'sd2147483648;
  localparam logic signed [P_W-22:0]  OUT_MAX = 42'sd8388607;
  localparam logic signed [P_W-22:0]  OUT_MIN = -42'sd8388608;

  logic signed [SMP_W-1:0]  smp_r [CHANNELS];
  logic [szl_pkg::COEF_W-1:0] g_r;
  logic [G_W-1:0]           gc_r, omg_r, coef_r;
  logic [G_W-1:0]           pw_r [STAGES+1];
  logic signed [ST_W-1:0]   st_r [NST];
  logic signed [S_W-1:0]    sum_r;
  logic signed [X_W-1:0]    x_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]         mag_r;
  logic                     neg_r;
  logic [DEN_W-1:0]         den_r;
  logic [A2_W-1:0]          a2_r;
  logic signed [V_W-1:0]    v_r;
  logic signed [P_W-1:0]    prod_r;
  logic [REM_W-1:0]         rem_r;
  logic [DSR_W-1:0]         dsr_r;
  logic [Q_W-1:0]           quot_r;
  logic signed [SMP_W-1:0]  y_r [szl_pkg::FIELDS];

  logic [SA_W-1:0]          st_addr;
  logic [G_W-1:0]           pw_rd;
  logic signed [ST_W-1:0]   st_rd;
  logic signed [V_W:0]      diff;
  logic [X_W-1:0]           n_an;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [P_W-1:0]    prod_full;
  logic [REM_W-1:0]         dvd;
  logic [DVS_W-1:0]         dvs;
  logic [REM_W-1:0]         dsr_ext;
  logic signed [D_W-1:0]    delta;
  logic signed [D_W-1:0]    vn;
  logic signed [S_W:0]      ssum;
  logic signed [ST_W-1:0]   st_sat;
  logic signed [P_W-22:0]   oshift;
  logic signed [SMP_W-1:0]  y_sat;
  logic [DEN_W+1:0]         den3;
  logic [V_W-1:0]           qv;

  assign st_addr = SA_W'(int'(cmd.ch) * STAGES + int'(cmd.idx));
  assign pw_rd   = pw_r[cmd.pw_addr];
  assign st_rd   = st_r[st_addr];
  assign diff    = (V_W+1)'(v_r) - (V_W+1)'(st_rd);
  assign n_an    = X_W'(C27) + X_W'(a2_r);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      szl_pkg::OP_PW_M: begin
        ma = MA_W'(pw_rd);
        mb = MB_W'(gc_r);
      end
      szl_pkg::OP_CO_M: begin
        ma = MA_W'(pw_rd);
        mb = MB_W'(omg_r);
      end
      szl_pkg::OP_SM_M: begin
        ma = MA_W'(st_rd);
        mb = MB_W'(coef_r);
      end
      szl_pkg::OP_X_M: begin
        ma = MA_W'(smp_r[cmd.ch]);
        mb = MB_W'(in_gain);
      end
      szl_pkg::OP_KS_M: begin
        ma = sum_r;
        mb = MB_W'(res_k);
      end
      szl_pkg::OP_KP_M: begin
        ma = MA_W'(pw_rd);
        mb = MB_W'(res_k);
      end
      szl_pkg::OP_A2_M: begin
        ma = MA_W'(quot_r);
        mb = MB_W'(quot_r);
      end
      szl_pkg::OP_AN_M: begin
        ma = MA_W'(n_an);
        mb = MB_W'(quot_r);
      end
      szl_pkg::OP_ST_M: begin
        ma = MA_W'(diff);
        mb = MB_W'(gc_r);
      end
      szl_pkg::OP_OUT_M: begin
        ma = MA_W'(v_r);
        mb = MB_W'(out_gain);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_full = P_W'(ma) * P_W'(mb);

  always_comb begin
    dvd = '0;
    dvs = '0;
    unique case (cmd.div_sel)
      szl_pkg::DIV_G: begin
        dvd = {16'b0, g_r, 24'b0};
        dvs = DVS_W'({1'b0, g_r} + G_BIAS);
      end
      szl_pkg::DIV_FB: begin
        dvd = {mag_r, 24'b0};
        dvs = DVS_W'(den_r);
      end
      szl_pkg::DIV_CLIP: begin
        dvd = {8'b0, prod_r[55:0]};
        dvs = C27 + {1'b0, a2_r, 3'b0} + DVS_W'(a2_r);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  assign dsr_ext = REM_W'(dsr_r);

  // Stage update: trapezoidal one-pole, state saturates to 32 bits.
  assign delta  = $signed(prod_r[D_W+23:24]);
  assign vn     = D_W'(st_rd) + delta;
  assign ssum   = (S_W+1)'(vn) + (S_W+1)'(delta);
  assign st_sat = (ssum > ST_MAX) ? ST_W'(ST_MAX) :
                  (ssum < ST_MIN) ? ST_W'(ST_MIN) : ssum[ST_W-1:0];

  assign oshift = $signed(prod_r[P_W-1:21]);
  assign y_sat  = (oshift > OUT_MAX) ? SMP_W'(OUT_MAX) :
                  (oshift < OUT_MIN) ? SMP_W'(OUT_MIN) : oshift[SMP_W-1:0];

  assign den3          = {2'b0, den_r} + {1'b0, den_r, 1'b0};
  assign stat.overload = mag_r >= NUM_W'(den3);
  assign qv            = V_W'(quot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) st_r[i] <= '0;
    end else if (cmd.op == szl_pkg::OP_ST_W) begin
      st_r[st_addr] <= st_sat;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      szl_pkg::OP_PW_M, szl_pkg::OP_CO_M, szl_pkg::OP_SM_M, szl_pkg::OP_X_M,
      szl_pkg::OP_KS_M, szl_pkg::OP_KP_M, szl_pkg::OP_A2_M, szl_pkg::OP_AN_M,
      szl_pkg::OP_ST_M, szl_pkg::OP_OUT_M: begin
        prod_r <= prod_full;
      end
      szl_pkg::OP_LOAD: begin
        for (int c = 0; c < CHANNELS; c++) smp_r[c] <= (c == 0) ? left_in : right_in;
        g_r <= cutoff_coef;
      end
      szl_pkg::OP_DIV_START: begin
        rem_r  <= dvd;
        dsr_r  <= {dvs, {(Q_W-1){1'b0}}};
        quot_r <= '0;
      end
      szl_pkg::OP_DIV_STEP: begin
        if (rem_r >= dsr_ext) begin
          rem_r  <= rem_r - dsr_ext;
          quot_r <= {quot_r[Q_W-2:0], 1'b1};
        end else begin
          quot_r <= {quot_r[Q_W-2:0], 1'b0};
        end
        dsr_r <= dsr_r >> 1;
      end
      szl_pkg::OP_G_SET: begin
        gc_r     <= quot_r[G_W-1:0];
        omg_r    <= ONE_G - quot_r[G_W-1:0];
        pw_r[0]  <= ONE_G;
      end
      szl_pkg::OP_PW_W: pw_r[cmd.idx] <= prod_r[G_W+23:24];
      szl_pkg::OP_CO_W: coef_r <= prod_r[G_W+23:24];
      szl_pkg::OP_SM_W: sum_r <= sum_r + $signed(prod_r[S_W+23:24]);
      szl_pkg::OP_X_W: begin
        x_r   <= $signed(prod_r[X_W+17:18]);
        sum_r <= '0;
      end
      szl_pkg::OP_KS_W: num_r <= NUM_W'(x_r) - $signed(prod_r[NUM_W+12:13]);
      szl_pkg::OP_KP_W: begin
        den_r <= ONE_G + prod_r[DEN_W+12:13];
        neg_r <= num_r[NUM_W-1];
        mag_r <= num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
      end
      szl_pkg::OP_U_ONE: v_r <= neg_r ? -ONE_V : ONE_V;
      szl_pkg::OP_A2_W:  a2_r <= prod_r[A2_W+23:24];
      szl_pkg::OP_V_SET: v_r <= neg_r ? -$signed(qv) : $signed(qv);
      szl_pkg::OP_ST_W:  v_r <= vn[V_W-1:0];
      szl_pkg::OP_OUT_W: y_r[cmd.ch] <= y_sat;
      szl_pkg::OP_PUBLISH: begin
        left_out  <= y_r[0];
        right_out <= (CHANNELS > 1) ? y_r[1] : '0;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/stereo_zdf_ladder_lowpass.sv
// Items are handled one at a time: a new item is accepted only in idle, once the
//   previous result is published. The shared divider runs one division for G and
//   two per channel; a channel whose feedback overdrives skips its two. All
//   products come from the single shared multiplier.
// Reset: synchronous, active low; clears the ladder state, loads register defaults.
`default_nettype none
module stereo_zdf_ladder_lowpass (
  input  wire logic clk,
  input  wire logic rst_n,
  szl_in_if.sink    in_ch,
  szl_out_if.source out_ch,
  szl_cfg_if.sink   cfg_ch
);

  logic [szl_pkg::K_W-1:0]    res_k_r;
  logic [szl_pkg::GAIN_W-1:0] in_gain_r;
  logic [szl_pkg::GAIN_W-1:0] out_gain_r;

  szl_pkg::dp_cmd_t  cmd;
  szl_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_k_r    <= szl_pkg::RES_K_RST;
      in_gain_r  <= szl_pkg::IN_GAIN_RST;
      out_gain_r <= szl_pkg::OUT_GAIN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        szl_pkg::REG_RES_K:    res_k_r    <= cfg_ch.data[szl_pkg::K_W-1:0];
        szl_pkg::REG_IN_GAIN:  in_gain_r  <= cfg_ch.data;
        szl_pkg::REG_OUT_GAIN: out_gain_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  szl_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  szl_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .left_in     (in_ch.left_in),
    .right_in    (in_ch.right_in),
    .cutoff_coef (in_ch.cutoff_coef),
    .res_k       (res_k_r),
    .in_gain     (in_gain_r),
    .out_gain    (out_gain_r),
    .left_out    (out_ch.left_out),
    .right_out   (out_ch.right_out)
  );

endmodule
`default_nettype wire

### verif/stereo_zdf_ladder_lowpass_tb.sv
`default_nettype none

class ladder_scoreboard;
  localparam int NST = szl_pkg::STAGES;
  localparam int NCH = szl_pkg::CHANNELS;
  localparam longint ONE = 64'sd1 << 24;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } frame_t;

  longint ladder[NCH*NST];
  longint res_k;
  longint in_gain;
  longint out_gain;
  frame_t pending_frames[$];
  int errors;

  function new();
    foreach (ladder[i]) ladder[i] = 0;
    res_k    = szl_pkg::RES_K_RST;
    in_gain  = szl_pkg::IN_GAIN_RST;
    out_gain = szl_pkg::OUT_GAIN_RST;
    errors   = 0;
  endfunction

  function void write_reg(logic [szl_pkg::REG_W-1:0] idx, logic [23:0] data);
    case (idx)
      szl_pkg::REG_RES_K:    res_k = data[15:0];
      szl_pkg::REG_IN_GAIN:  in_gain = data;
      szl_pkg::REG_OUT_GAIN: out_gain = data;
      default: ;
    endcase
  endfunction

  function longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Solve the feedback for one channel, advance its stages, return last stage output.
  function longint ladder_channel(int c, longint x, longint g_lp);
    longint pw[NST+1];
    longint omg, s_sum, coef, num, den, u, v, delta;
    longint unsigned mag, q, a2, n, d;
    bit neg;
    pw[0] = ONE;
    for (int i = 1; i <= NST; i++) pw[i] = (pw[i-1] * g_lp) >>> 24;
    omg = ONE - g_lp;
    s_sum = 0;
    for (int i = 0; i < NST; i++) begin
      coef = (pw[NST-1-i] * omg) >>> 24;
      s_sum += (coef * ladder[c*NST+i]) >>> 24;
    end
    num = x - ((res_k * s_sum) >>> 13);
    den = ONE + ((res_k * pw[NST]) >>> 13);
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag >= 3 * longint'(den)) begin
      u = ONE;
    end else begin
      q  = (mag << 24) / den;
      a2 = (q * q) >> 24;
      n  = 27 * ONE + a2;
      d  = 27 * ONE + 9 * a2;
      u  = (q * n) / d;
    end
    v = neg ? -u : u;
    for (int i = 0; i < NST; i++) begin
      delta = ((v - ladder[c*NST+i]) * g_lp) >>> 24;
      v = ladder[c*NST+i] + delta;
      ladder[c*NST+i] = clamp(v + delta, -(64'sd1 << 31), (64'sd1 << 31) - 1);
    end
    return v;
  endfunction

  function void note_frame(logic signed [23:0] l, logic signed [23:0] r, logic [23:0] g);
    longint unsigned gu;
    longint g_lp, s, x, v, y[2];
    frame_t f;
    gu = g;
    g_lp = (gu << 24) / (gu + (64'd1 << 20));
    for (int c = 0; c < 2; c++) begin
      y[c] = 0;
      if (c < NCH) begin
        s = (c == 0) ? longint'(l) : longint'(r);
        x = (s * in_gain) >>> 18;
        v = ladder_channel(c, x, g_lp);
        y[c] = clamp((v * out_gain) >>> 21, -8388608, 8388607);
      end
    end
    f.left  = y[0][23:0];
    f.right = y[1][23:0];
    pending_frames.push_back(f);
  endfunction

  function void check_frame(logic signed [23:0] l, logic signed [23:0] r);
    frame_t f;
    if (pending_frames.size() == 0) begin
      $display("%0t: unexpected result left=%0d right=%0d", $realtime, l, r);
      errors++;
      return;
    end
    f = pending_frames.pop_front();
    if (f.left !== l) begin
      $display("%0t: left_out expected %0d actual %0d", $realtime, f.left, l);
      errors++;
    end
    if (f.right !== r) begin
      $display("%0t: right_out expected %0d actual %0d", $realtime, f.right, r);
      errors++;
    end
  endfunction

  function int waiting();
    return pending_frames.size();
  endfunction
endclass

module stereo_zdf_ladder_lowpass_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [szl_pkg::REG_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE = 300;
  localparam int HOLD_CYCLES = 3000;
  localparam logic signed [23:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SMP_MIN = 24'sh800000;
  localparam logic [23:0] G_ONE = 24'h100000;

  logic clk;
  logic rst_n;
  szl_in_if  in_bus();
  szl_out_if out_bus();
  szl_cfg_if cfg_bus();

  ladder_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_ack;
  int hold_left;

  stereo_zdf_ladder_lowpass dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus), .cfg_ch(cfg_bus)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Sample both handshakes before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_frame(in_bus.left_in, in_bus.right_in, in_bus.cutoff_coef);
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_frame(out_bus.left_out, out_bus.right_out);
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r, logic [23:0] g);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.left_in     <= l;
    in_bus.right_in    <= r;
    in_bus.cutoff_coef <= g;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [szl_pkg::REG_W-1:0] idx, logic [23:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Hold the sender until every expected result is back, then let the block settle.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? SMP_MAX : SMP_MIN;
      1: return 24'($signed($urandom_range(512)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_coef();
    case ($urandom_range(9))
      0, 1, 2: return 24'($urandom);
      3: return 24'd0;
      4: return 24'hFFFFFF;
      default: return 24'($urandom_range(G_ONE));
    endcase
  endfunction

  initial begin
    logic [15:0] k_tab[9]  = '{16'd8192, 16'd0, 16'd33177, 16'hFFFF, 16'd16384,
                                16'd33177, 16'd0, 16'd1000, 16'd8192};
    logic [23:0] ig_tab[9] = '{24'd524288, 24'd524288, 24'd1048576, 24'hFFFFFF, 24'd0,
                                24'd2097152, 24'd0, 24'd262144, 24'd524288};
    logic [23:0] og_tab[9] = '{24'd1048576, 24'd1048576, 24'd1048576, 24'hFFFFFF,
                                24'd1048576, 24'd0, 24'd0, 24'd4194304, 24'd1048576};
    rst_n = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.left_in <= '0;
    in_bus.right_in <= '0;
    in_bus.cutoff_coef <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: extremes, full-scale swings, overload
    send_frame(0, 0, 0);
    send_frame(SMP_MAX, SMP_MAX, 0);
    send_frame(SMP_MIN, SMP_MIN, 24'hFFFFFF);
    send_frame(SMP_MAX, SMP_MIN, G_ONE);
    send_frame(SMP_MIN, SMP_MAX, G_ONE);
    repeat (4) send_frame(SMP_MAX, SMP_MAX, 24'hFFFFFF);
    repeat (4) send_frame(SMP_MIN, SMP_MAX, 24'h800000);
    send_frame(0, 0, G_ONE);
    send_frame(1, -1, 24'hFFFFFF);
    send_frame(-1, 1, 24'd1);
    send_frame(24'sh400000, -24'sh400000, 24'h040000);
    send_frame(24'sh000100, 24'sh7FFF00, 24'h555555);
    send_frame(24'sh2AAAAA, 24'shD55555, 24'hAAAAAA);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin send_idle_pct = 34; recv_idle_pct = 76; end
        1: begin send_idle_pct = 76; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 3) write_reg(REG_UNUSED, 24'h123456);
      write_reg(szl_pkg::REG_RES_K, {8'hA5, k_tab[ph]});
      write_reg(szl_pkg::REG_IN_GAIN, ig_tab[ph]);
      write_reg(szl_pkg::REG_OUT_GAIN, og_tab[ph]);
      for (int n = 0; n < 220; n++) begin
        if (ph == 4 && n == 10) hold_req++;
        send_frame(pick_sample(), pick_sample(), pick_coef());
      end
      drain();
    end

    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
